// ===== rtl/lfsia_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfsia_pkg: shared constants and types for the seat allocator
// Seat count, time width and the field types used by the top level and the
// port checker.
// ----------------------------------------------------------------------------
package lfsia_pkg;

   localparam int SEATS     = 64;
   localparam int TIME_BITS = 20;
   localparam int USES_BITS = 16;
   localparam int SEAT_W    = (SEATS > 1) ? $clog2(SEATS) : 1;
   localparam int OPEN_W    = $clog2(SEATS + 1);

   typedef logic [TIME_BITS-1:0] time_type;
   typedef logic [USES_BITS-1:0] uses_type;
   typedef logic [SEAT_W-1:0]    seat_idx_type;
   typedef logic [OPEN_W-1:0]    open_cnt_type;
   typedef logic [SEATS-1:0]     seat_vec_type;

endpackage
`default_nettype wire

// ===== rtl/lowest_free_seat_interval_allocator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// An accepted transaction waits in the input register, then moves to the result register.
// Throughput: 1 interval per cycle unless rsp_ready stalls the result register; all seats
// are compared in parallel in the single stage between the input register and the result
// register. Reset clears the open-seat count and both valid flags; the seat end-time
// and use-count tables are not cleared, only seats below the count are read.
// ----------------------------------------------------------------------------
// lowest_free_seat_interval_allocator
// Places each interval on the lowest-numbered free seat, opens a new seat if
// none is free, flags overflow when every seat is open and busy.
// ----------------------------------------------------------------------------
module lowest_free_seat_interval_allocator (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire lfsia_pkg::time_type     req_start_time,
   input  wire lfsia_pkg::time_type     req_end_time,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output lfsia_pkg::seat_idx_type      rsp_seat_index,
   output lfsia_pkg::uses_type          rsp_seat_uses,
   output lfsia_pkg::open_cnt_type      rsp_seats_open,
   output logic                         rsp_opened_new,
   output logic                         rsp_overflow
);

   // input register
   logic                    in_valid_ff, in_valid_in;
   lfsia_pkg::time_type     in_start_ff;
   lfsia_pkg::time_type     in_end_ff;

   // seat state
   lfsia_pkg::time_type     seat_end_ff  [lfsia_pkg::SEATS];
   lfsia_pkg::uses_type     seat_uses_ff [lfsia_pkg::SEATS];
   lfsia_pkg::open_cnt_type open_ff, open_in;

   // result register
   logic                    rsp_valid_ff, rsp_valid_in;
   lfsia_pkg::seat_idx_type rsp_index_ff;
   lfsia_pkg::uses_type     rsp_uses_ff;
   lfsia_pkg::open_cnt_type rsp_open_ff;
   logic                    rsp_new_ff;
   logic                    rsp_ovf_ff;

   logic                    advance;
   lfsia_pkg::seat_vec_type free_vec;
   lfsia_pkg::seat_vec_type grant;
   logic                    any_free;
   logic                    full;
   logic                    open_new;
   logic                    write_en;
   lfsia_pkg::seat_idx_type pick_idx;
   lfsia_pkg::uses_type     pick_uses;
   lfsia_pkg::uses_type     bumped_uses;
   lfsia_pkg::seat_idx_type tgt_idx;
   lfsia_pkg::uses_type     tgt_uses;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      for (int i = 0; i < lfsia_pkg::SEATS; i++) begin
         free_vec[i] = (lfsia_pkg::OPEN_W'(i) < open_ff) && (seat_end_ff[i] <= in_start_ff);
      end
   end

   // isolate lowest set bit
   assign grant    = free_vec & (~free_vec + lfsia_pkg::seat_vec_type'(1));
   assign any_free = |free_vec;
   assign full     = (open_ff == lfsia_pkg::OPEN_W'(lfsia_pkg::SEATS));
   assign open_new = !any_free && !full;

   // one-hot mux of index and use count
   always_comb begin
      pick_idx  = '0;
      pick_uses = '0;
      for (int i = 0; i < lfsia_pkg::SEATS; i++) begin
         if (grant[i]) begin
            pick_idx  = pick_idx | lfsia_pkg::SEAT_W'(i);
            pick_uses = pick_uses | seat_uses_ff[i];
         end
      end
   end

   assign bumped_uses = (pick_uses == '1) ? pick_uses : pick_uses + lfsia_pkg::uses_type'(1);
   assign tgt_idx     = any_free ? pick_idx : open_ff[lfsia_pkg::SEAT_W-1:0];
   assign tgt_uses    = any_free ? bumped_uses : lfsia_pkg::uses_type'(1);
   assign write_en    = advance && (any_free || open_new);
   assign open_in     = (advance && open_new) ? open_ff + lfsia_pkg::open_cnt_type'(1) : open_ff;

   assign in_valid_in  = (req_valid && req_ready) || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         open_ff      <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         open_ff      <= open_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_start_ff <= req_start_time;
         in_end_ff   <= req_end_time;
      end
   end

   always_ff @(posedge clock) begin
      if (write_en) begin
         seat_end_ff[tgt_idx]  <= in_end_ff;
         seat_uses_ff[tgt_idx] <= tgt_uses;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_index_ff <= full && !any_free ? '0 : tgt_idx;
         rsp_uses_ff  <= full && !any_free ? '0 : tgt_uses;
         rsp_open_ff  <= open_in;
         rsp_new_ff   <= open_new;
         rsp_ovf_ff   <= full && !any_free;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_seat_index = rsp_index_ff;
   assign rsp_seat_uses  = rsp_uses_ff;
   assign rsp_seats_open = rsp_open_ff;
   assign rsp_opened_new = rsp_new_ff;
   assign rsp_overflow   = rsp_ovf_ff;

endmodule
`default_nettype wire

// ===== rtl/lfsia_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfsia_checker: port-level checks for the seat allocator
// Watches the result channel and ties the reported fields together.
// ----------------------------------------------------------------------------
module lfsia_checker (
   input wire logic                    clock,
   input wire logic                    reset,
   input wire logic                    rsp_valid,
   input wire logic                    rsp_ready,
   input wire lfsia_pkg::seat_idx_type rsp_seat_index,
   input wire lfsia_pkg::uses_type     rsp_seat_uses,
   input wire lfsia_pkg::open_cnt_type rsp_seats_open,
   input wire logic                    rsp_opened_new,
   input wire logic                    rsp_overflow
);

   // a stalled transaction holds its payload
   property p_rsp_hold;
      @(posedge clock) disable iff (reset)
         rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_seat_index)
            && $stable(rsp_seat_uses) && $stable(rsp_seats_open)
            && $stable(rsp_opened_new) && $stable(rsp_overflow);
   endproperty
   a_rsp_hold: assert property (p_rsp_hold) else $error("rsp payload changed under stall");

   // overflow only with every seat open, nothing placed
   property p_overflow;
      @(posedge clock) disable iff (reset)
         rsp_valid && rsp_overflow |->
            rsp_seats_open == lfsia_pkg::OPEN_W'(lfsia_pkg::SEATS) && !rsp_opened_new
            && rsp_seat_index == '0 && rsp_seat_uses == '0;
   endproperty
   a_overflow: assert property (p_overflow) else $error("bad overflow result");

   // a fresh seat is the last one opened and has one use
   property p_new_seat;
      @(posedge clock) disable iff (reset)
         rsp_valid && rsp_opened_new |->
            rsp_seat_uses == lfsia_pkg::uses_type'(1)
            && lfsia_pkg::OPEN_W'(rsp_seat_index) + lfsia_pkg::open_cnt_type'(1)
               == rsp_seats_open;
   endproperty
   a_new_seat: assert property (p_new_seat) else $error("bad new-seat result");

   // a placed interval sits on an open seat with a nonzero count
   property p_placed;
      @(posedge clock) disable iff (reset)
         rsp_valid && !rsp_overflow |->
            lfsia_pkg::OPEN_W'(rsp_seat_index) < rsp_seats_open && rsp_seat_uses != '0;
   endproperty
   a_placed: assert property (p_placed) else $error("placed on unopened seat");

   // no result right after reset
   property p_reset;
      @(posedge clock) reset |=> !rsp_valid;
   endproperty
   a_reset: assert property (p_reset) else $error("rsp_valid after reset");

endmodule

bind lowest_free_seat_interval_allocator lfsia_checker u_lfsia_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_seat_index (rsp_seat_index),
   .rsp_seat_uses  (rsp_seat_uses),
   .rsp_seats_open (rsp_seats_open),
   .rsp_opened_new (rsp_opened_new),
   .rsp_overflow   (rsp_overflow)
);
`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: lowest-free-seat interval allocator
// Drives intervals over valid/ready with random gaps on both sides and checks
// every result against an in-bench seat table or a typed expectation. Covers a
// directed run of extremes, an overflow fill and a random stream of mostly
// sorted intervals with varying load.
// ----------------------------------------------------------------------------
module testbench;

   localparam int          RANDOM_ITEMS = 1870;
   localparam int          FILL_ITEMS   = 66;
   localparam int          HOLD_CYCLES  = 300;
   localparam int          HOLD_AT      = 500;
   localparam int          DRAIN_CYCLES = 10;
   localparam int          STALL_LIMIT  = 2000;
   localparam int unsigned TIME_MAX     = (2 ** lfsia_pkg::TIME_BITS) - 1;

   typedef struct packed {
      lfsia_pkg::seat_idx_type seat_index;
      lfsia_pkg::uses_type     seat_uses;
      lfsia_pkg::open_cnt_type seats_open;
      logic                    opened_new;
      logic                    overflow;
   } placement_type;

   typedef struct packed {
      lfsia_pkg::time_type t_start;
      lfsia_pkg::time_type t_stop;
      logic                typed;
      placement_type       want;
   } interval_row_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   lfsia_pkg::time_type     req_start_time = '0;
   lfsia_pkg::time_type     req_end_time = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   lfsia_pkg::seat_idx_type rsp_seat_index;
   lfsia_pkg::uses_type     rsp_seat_uses;
   lfsia_pkg::open_cnt_type rsp_seats_open;
   logic                    rsp_opened_new;
   logic                    rsp_overflow;

   // seat table mirrored by the bench
   lfsia_pkg::time_type seat_end_mem  [lfsia_pkg::SEATS];
   lfsia_pkg::uses_type seat_uses_mem [lfsia_pkg::SEATS];
   int unsigned         seats_opened = 0;

   placement_type placements_due[$];
   int            faults = 0;
   int            n_sent = 0;
   int            n_checked = 0;
   int            n_overflow = 0;
   int            stall_cycles = 0;
   bit            hold_pending = 1'b0;

   lowest_free_seat_interval_allocator uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_start_time (req_start_time),
      .req_end_time   (req_end_time),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_seat_index (rsp_seat_index),
      .rsp_seat_uses  (rsp_seat_uses),
      .rsp_seats_open (rsp_seats_open),
      .rsp_opened_new (rsp_opened_new),
      .rsp_overflow   (rsp_overflow)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // lowest free seat, else open the next one, else overflow with no change
   function automatic placement_type place_interval(input lfsia_pkg::time_type s,
                                                    input lfsia_pkg::time_type e);
      placement_type r;
      int            pick;
      r    = '0;
      pick = -1;
      for (int i = 0; i < seats_opened; i++) begin
         if (pick < 0 && seat_end_mem[i] <= s) pick = i;
      end
      if (pick < 0 && seats_opened < lfsia_pkg::SEATS) begin
         pick                = seats_opened;
         seat_uses_mem[pick] = '0;
         seats_opened++;
         r.opened_new = 1'b1;
      end
      if (pick < 0) begin
         r.overflow = 1'b1;
      end else begin
         seat_end_mem[pick] = e;
         if (seat_uses_mem[pick] != '1) seat_uses_mem[pick]++;
         r.seat_index = lfsia_pkg::seat_idx_type'(pick);
         r.seat_uses  = seat_uses_mem[pick];
      end
      r.seats_open = lfsia_pkg::open_cnt_type'(seats_opened);
      return r;
   endfunction

   // offer one interval; the placement is worked out at the accepting edge
   task automatic offer_interval(input lfsia_pkg::time_type s, input lfsia_pkg::time_type e,
                                 input int gap, input logic typed,
                                 input placement_type want);
      placement_type p;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_start_time <= s;
      req_end_time   <= e;
      do @(posedge clock); while (!req_ready);
      p = place_interval(s, e);
      placements_due = {placements_due, (typed ? want : p)};
      n_sent++;
   endtask

   // result side: random back-pressure, one long hold-off on request
   initial begin : result_side
      placement_type want;
      int            gap;
      bit            rsp_burst;
      rsp_burst = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (n_checked % 50 == 0) rsp_burst = ($urandom_range(0, 3) == 0);
         gap = rsp_burst ? 0 : $urandom_range(0, 12);
         if (hold_pending) begin
            gap          = HOLD_CYCLES;
            hold_pending = 1'b0;
         end
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         if (placements_due.size() == 0) begin
            $error("result with no transaction outstanding");
            faults++;
         end else begin
            want = placements_due.pop_front();
            if (rsp_seat_index !== want.seat_index) begin
               $error("seat_index: expected %0d, got %0d", want.seat_index, rsp_seat_index);
               faults++;
            end
            if (rsp_seat_uses !== want.seat_uses) begin
               $error("seat_uses: expected %0d, got %0d", want.seat_uses, rsp_seat_uses);
               faults++;
            end
            if (rsp_seats_open !== want.seats_open) begin
               $error("seats_open: expected %0d, got %0d", want.seats_open, rsp_seats_open);
               faults++;
            end
            if (rsp_opened_new !== want.opened_new) begin
               $error("opened_new: expected %0b, got %0b", want.opened_new, rsp_opened_new);
               faults++;
            end
            if (rsp_overflow !== want.overflow) begin
               $error("overflow: expected %0b, got %0b", want.overflow, rsp_overflow);
               faults++;
            end
            if (want.overflow) n_overflow++;
         end
         n_checked++;
      end
   end

   // watchdog: cycles in a row with no transaction on either side
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("testbench: errors");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin : stimulus
      interval_row_type directed_rows[$];
      int unsigned      cursor;
      int unsigned      start_val;
      int unsigned      stop_val;
      int unsigned      prev_stop;
      int unsigned      step;
      int unsigned      span;
      int               kind;
      bit               send_burst;

      directed_rows = '{
         '{20'h00000, 20'h00000, 1'b1, '{6'd0, 16'd1, 7'd1, 1'b1, 1'b0}},
         '{20'h00000, 20'hFFFFF, 1'b1, '{6'd0, 16'd2, 7'd1, 1'b0, 1'b0}},
         '{20'h00000, 20'h00005, 1'b1, '{6'd1, 16'd1, 7'd2, 1'b1, 1'b0}},
         '{20'hFFFFF, 20'h00000, 1'b1, '{6'd0, 16'd3, 7'd2, 1'b0, 1'b0}},
         '{20'h00003, 20'h00003, 1'b0, '0},
         '{20'h00005, 20'h0000A, 1'b0, '0},
         '{20'h00005, 20'h00007, 1'b0, '0},
         '{20'h00006, 20'h00001, 1'b0, '0},
         '{20'h00007, 20'h00008, 1'b0, '0},
         '{20'hAAAAA, 20'h55555, 1'b0, '0},
         '{20'h55555, 20'hAAAAA, 1'b0, '0},
         '{20'hFFFFF, 20'h00000, 1'b0, '0},
         '{20'h00002, 20'h00002, 1'b0, '0}
      };

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         offer_interval(directed_rows[i].t_start, directed_rows[i].t_stop,
                        $urandom_range(0, 12), directed_rows[i].typed,
                        directed_rows[i].want);

      // reuse the open seats, open the rest, then two intervals overflow
      for (int i = 0; i < FILL_ITEMS; i++)
         offer_interval(lfsia_pkg::time_type'(100), lfsia_pkg::time_type'(200),
                        $urandom_range(0, 12), 1'b0, '0);

      cursor     = 200;
      prev_stop  = 200;
      span       = 0;
      send_burst = 1'b0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 64 == 0) begin
            span       = $urandom_range(0, 24000);
            send_burst = ($urandom_range(0, 3) == 0);
         end
         if (n == HOLD_AT) hold_pending = 1'b1;
         kind = $urandom_range(0, 99);
         if (kind < 88) begin
            step   = $urandom_range(0, 300);
            cursor = cursor + step;
            if (cursor > TIME_MAX) cursor = TIME_MAX;
            start_val = cursor;
            stop_val  = cursor + $urandom_range(0, span);
            if (step == 0 && stop_val < prev_stop) stop_val = prev_stop;
         end else if (kind < 98) begin
            // out of order start
            start_val = $urandom_range(0, cursor);
            stop_val  = start_val + $urandom_range(0, span);
         end else if (kind < 99) begin
            // end at or before start
            start_val = cursor;
            stop_val  = $urandom_range(0, cursor);
         end else begin
            start_val = $urandom_range(0, TIME_MAX);
            stop_val  = $urandom_range(0, cursor + span);
         end
         if (stop_val > TIME_MAX) stop_val = TIME_MAX;
         if (kind < 88) prev_stop = stop_val;
         offer_interval(lfsia_pkg::time_type'(start_val), lfsia_pkg::time_type'(stop_val),
                        send_burst ? 0 : $urandom_range(0, 12), 1'b0, '0);
      end
      req_valid <= 1'b0;

      while (placements_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d intervals and %0d results, %0d seats opened", n_sent, n_checked,
               seats_opened);
      $display("overflow results: %0d", n_overflow);
      if (faults == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule
